>>> sv/sss_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the substring search block.
// No dependencies.
package sss_pkg;

    // Register codes (APB address bits [4:3])
    localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [1:0] REG_SEARCH_MODE    = 2'd2;
    localparam logic [1:0] REG_START_OFFSET   = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

    localparam logic MODE_FIRST = 1'b0;
    localparam logic MODE_LAST  = 1'b1;

    typedef struct packed {
        logic [7:0] subject_byte;
        logic       last_of_subject;
    } t_in;

    typedef struct packed {
        logic [1:0]  search_status;
        logic [15:0] match_position;
    } t_out;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic        search_mode;
        logic [15:0] start_offset;
    } t_cfg;

endpackage

>>> sv/sss_cell.sv
`timescale 1ns / 1ps
// One window cell: holds a subject byte, passes it on, compares the byte
// it is about to take against its pattern byte. No dependencies.
module sss_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat,
    output logic [7:0] o_byte,
    output logic       o_eq
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_eq   = (i_byte == i_pat);

endmodule

>>> sv/sss_regs.sv
`timescale 1ns / 1ps
// APB register file for the substring search configuration.
// Depends on sss_pkg.
module sss_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output sss_pkg::t_cfg      o_cfg
);

    import sss_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (paddr[4:3])
                REG_PATTERN_BYTES:  r_cfg.pattern_bytes  <= pwdata;
                REG_PATTERN_LENGTH: r_cfg.pattern_length <= pwdata[3:0];
                REG_SEARCH_MODE:    r_cfg.search_mode    <= pwdata[0];
                REG_START_OFFSET:   r_cfg.start_offset   <= pwdata[15:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_PATTERN_BYTES:  prdata = r_cfg.pattern_bytes;
            REG_PATTERN_LENGTH: prdata = {60'd0, r_cfg.pattern_length};
            REG_SEARCH_MODE:    prdata = {63'd0, r_cfg.search_mode};
            REG_START_OFFSET:   prdata = {48'd0, r_cfg.start_offset};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/substring_search_first_last.sv
`timescale 1ns / 1ps
// Streaming substring search, first or last match. Depends on sss_pkg,
// sss_cell and sss_regs.
//
// Subject bytes enter one item per cycle into a row of PATTERN_MAX cells
// that shift the window along on every accepted item; each cell compares
// the byte it takes with its pattern byte, so a match ending on the new
// byte is known in the same cycle. The pattern (up to 8 bytes, byte 0 in
// bits 7..0), its length, the mode and the start offset come from four
// APB registers at byte addresses 0, 8, 16 and 24 (64-bit data); write
// them only between subjects. First mode keeps the earliest match that
// starts at or after start_offset, last mode the latest match. On the
// item flagged last_of_subject one result item comes out in the next
// cycle, from an output register: found with the start position, not
// found, or too long when the subject exceeds 2^POS_BITS - 1 bytes.
// Throughput is one byte per cycle; the input stalls only when a final
// byte arrives while the previous result is still held by a stalled
// output.
module substring_search_first_last #(
    parameter int PATTERN_MAX = 8,
    parameter int POS_BITS    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // subject item channel
    input  logic          i_in_valid,
    input  sss_pkg::t_in  i_in,
    output logic          o_in_stall,
    // result item channel
    output logic          o_out_valid,
    output sss_pkg::t_out o_out,
    input  logic          i_out_stall,
    // configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    import sss_pkg::*;

    // compare width: covers the byte count, its +1, and start_offset
    localparam int CW = (POS_BITS >= 16) ? POS_BITS + 1 : 17;

    t_cfg w_cfg;

    sss_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic w_in_acc;
    assign o_in_stall = o_out_valid & i_out_stall & i_in.last_of_subject;
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    // active pattern length, clamped to the cell count
    logic [3:0] w_len;
    assign w_len = (w_cfg.pattern_length > 4'(PATTERN_MAX)) ?
                   4'(PATTERN_MAX) : w_cfg.pattern_length;

    // ---- window cells: cell 0 takes the new byte, cell k the byte k back
    logic [7:0] w_cell_in  [PATTERN_MAX];
    logic [7:0] w_cell_out [PATTERN_MAX];
    logic [7:0] w_cell_pat [PATTERN_MAX];
    logic       w_cell_eq  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_ok;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            logic [3:0] w_sel;
            // cell k lines up with pattern byte len-1-k
            assign w_sel = w_len - 4'd1 - 4'(k);
            assign w_cell_pat[k] = w_cfg.pattern_bytes[{w_sel[2:0], 3'b000} +: 8];
            if (k == 0) begin : g_head
                assign w_cell_in[k] = i_in.subject_byte;
            end else begin : g_link
                assign w_cell_in[k] = w_cell_out[k-1];
            end
            // cells beyond the active length do not take part
            assign w_ok[k] = w_cell_eq[k] | (4'(k) >= w_len);

            sss_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_in_acc),
                .i_byte  (w_cell_in[k]),
                .i_pat   (w_cell_pat[k]),
                .o_byte  (w_cell_out[k]),
                .o_eq    (w_cell_eq[k])
            );
        end
    endgenerate

    // ---- subject bookkeeping
    logic [POS_BITS:0]   r_seen;     // saturates at 2^POS_BITS
    logic                r_match;
    logic [POS_BITS-1:0] r_rec;
    logic [POS_BITS:0]   n_seen;
    logic                n_match;
    logic [POS_BITS-1:0] n_rec;

    logic          w_sat;
    logic [CW-1:0] w_idx1;    // position just past the new byte
    logic [CW-1:0] w_start;
    logic [CW-1:0] w_len_cw;
    logic [CW-1:0] w_spos;    // candidate match start
    logic          w_hit;

    assign w_sat    = r_seen[POS_BITS];
    assign w_idx1   = CW'(r_seen) + CW'(1);
    assign w_start  = CW'(w_cfg.start_offset);
    assign w_len_cw = CW'(w_len);
    assign w_spos   = w_idx1 - w_len_cw;
    assign w_hit    = (w_len != 4'd0) & ~w_sat & (w_idx1 >= w_len_cw) & (&w_ok);
    assign n_seen   = w_sat ? r_seen : r_seen + (POS_BITS+1)'(1);

    always_comb begin
        n_match = r_match;
        n_rec   = r_rec;
        if (w_hit) begin
            if (w_cfg.search_mode == MODE_LAST) begin
                n_match = 1'b1;
                n_rec   = w_spos[POS_BITS-1:0];
            end else if (!r_match && (w_spos >= w_start)) begin
                n_match = 1'b1;
                n_rec   = w_spos[POS_BITS-1:0];
            end
        end
    end

    // ---- result of a subject, formed on its final byte
    t_out          w_res;
    logic [CW-1:0] w_pos;
    logic [CW-1:0] w_total;

    assign w_total = CW'(n_seen);

    always_comb begin
        w_pos = '0;
        priority if (n_seen[POS_BITS]) begin
            w_res.search_status = STATUS_TOO_LONG;
        end else if (w_len == 4'd0) begin
            // empty pattern
            if (w_cfg.search_mode == MODE_LAST) begin
                w_res.search_status = STATUS_FOUND;
                w_pos = w_total;
            end else if (w_start <= w_total) begin
                w_res.search_status = STATUS_FOUND;
                w_pos = w_start;
            end else begin
                w_res.search_status = STATUS_NOT_FOUND;
            end
        end else if (n_match) begin
            w_res.search_status = STATUS_FOUND;
            w_pos = CW'(n_rec);
        end else begin
            w_res.search_status = STATUS_NOT_FOUND;
        end
        w_res.match_position = w_pos[15:0];
    end

    // ---- state and output register
    t_out r_out;
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_match     <= 1'b0;
            r_rec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                if (i_in.last_of_subject) begin
                    r_seen  <= '0;
                    r_match <= 1'b0;
                    r_rec   <= '0;
                end else begin
                    r_seen  <= n_seen;
                    r_match <= n_match;
                    r_rec   <= n_rec;
                end
            end
            if (w_in_acc && i_in.last_of_subject) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.last_of_subject) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> test/substring_search_first_last_test.sv
`timescale 1ns / 1ps
// Testbench for substring_search_first_last. It runs directed and random subjects
// and checks each result item against its own prediction. Depends on sss_pkg and the block.
module substring_search_first_last_test;
    import sss_pkg::*;

    localparam int POS_LIMIT    = 65536;   // 2^POS_BITS
    localparam int PAT_MAX      = 8;
    localparam int QUIET_LIMIT  = 5000;    // cycles with no handshake at all
    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_CYCLES  = 300;
    localparam int LONG_LEN     = 100;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in         i_in        = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [4:0]  paddr       = '0;
    logic [63:0] pwdata      = '0;
    logic [63:0] prdata;
    logic        pready;

    // Register copy held by the search predictor
    logic [63:0] cfg_pattern = '0;
    logic [3:0]  cfg_length  = '0;
    logic        cfg_mode    = MODE_FIRST;
    logic [15:0] cfg_start   = '0;

    // Subject state held by the search predictor
    logic [63:0] win_bytes   = '0;
    int unsigned bytes_taken = 0;
    logic        have_match  = 1'b0;
    logic [15:0] match_start = '0;

    t_out        pending_results[$];
    logic [7:0]  subject_text[$];

    int errors       = 0;
    int items_sent   = 0;
    int in_gap_max   = 4;
    int out_gap_max  = 4;
    int out_wait     = 0;
    int hold_cycles  = 0;
    int quiet_cycles = 0;

    substring_search_first_last dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 40) begin
            $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        end
        errors++;
    endtask

    // Advances the predicted search by one subject byte; on the final byte
    // the predicted result item is queued and the subject state cleared.
    task automatic predict_byte(input t_in item);
        int unsigned n;
        int unsigned idx;
        int unsigned s;
        int          j;
        logic        hit;
        t_out        res;
        n   = (cfg_length > PAT_MAX) ? PAT_MAX : cfg_length;
        idx = bytes_taken;
        win_bytes = {win_bytes[55:0], item.subject_byte};
        if (bytes_taken < POS_LIMIT) begin
            bytes_taken++;
        end
        if (n > 0 && idx < POS_LIMIT && idx + 1 >= n) begin
            hit = 1'b1;
            for (j = 0; j < n; j++) begin
                // pattern byte 0 lines up with the oldest byte of the window
                if (win_bytes[(n - 1 - j) * 8 +: 8] != cfg_pattern[j * 8 +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                s = idx + 1 - n;
                if (cfg_mode == MODE_LAST || (!have_match && s >= cfg_start)) begin
                    have_match  = 1'b1;
                    match_start = s[15:0];
                end
            end
        end
        if (item.last_of_subject) begin
            res = '0;
            if (bytes_taken >= POS_LIMIT) begin
                res.search_status = STATUS_TOO_LONG;
            end else if (n == 0) begin
                // empty pattern: subject length in last mode, start offset (if reached) in first mode
                if (cfg_mode == MODE_LAST) begin
                    res.search_status  = STATUS_FOUND;
                    res.match_position = bytes_taken[15:0];
                end else if (cfg_start <= bytes_taken) begin
                    res.search_status  = STATUS_FOUND;
                    res.match_position = cfg_start;
                end else begin
                    res.search_status = STATUS_NOT_FOUND;
                end
            end else if (have_match) begin
                res.search_status  = STATUS_FOUND;
                res.match_position = match_start;
            end else begin
                res.search_status = STATUS_NOT_FOUND;
            end
            pending_results.push_back(res);
            win_bytes   = '0;
            bytes_taken = 0;
            have_match  = 1'b0;
            match_start = '0;
        end
    endtask

    // Setup cycle, access cycle, then the port is released.
    task automatic apb_write(input logic [1:0] code, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {code, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (code)
            REG_PATTERN_BYTES:  cfg_pattern = value;
            REG_PATTERN_LENGTH: cfg_length  = value[3:0];
            REG_SEARCH_MODE:    cfg_mode    = value[0];
            REG_START_OFFSET:   cfg_start   = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the caller sends again or goes quiet.
    task automatic send_item(input logic [7:0] b, input logic last);
        int  gap;
        t_in item;
        gap  = $urandom_range(in_gap_max);
        item.subject_byte    = b;
        item.last_of_subject = last;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall);
        predict_byte(item);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic go_quiet();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Sender pauses until every predicted result item has come back.
    task automatic wait_idle();
        go_quiet();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic reconfigure(input logic [63:0] pat, input logic [3:0] len,
                               input logic mode, input logic [15:0] start);
        wait_idle();
        apb_write(REG_PATTERN_BYTES, pat);
        apb_write(REG_PATTERN_LENGTH, 64'(len));
        apb_write(REG_SEARCH_MODE, 64'(mode));
        apb_write(REG_START_OFFSET, 64'(start));
    endtask

    task automatic send_subject();
        int i;
        for (i = 0; i < subject_text.size(); i++) begin
            send_item(subject_text[i], i == subject_text.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        int i;
        subject_text.delete();
        for (i = 0; i < s.len(); i++) begin
            subject_text.push_back(s[i]);
        end
        send_subject();
    endtask

    function automatic logic [63:0] pack_text(input string s);
        logic [63:0] v;
        int          i;
        v = '0;
        for (i = 0; i < s.len() && i < PAT_MAX; i++) begin
            v[i * 8 +: 8] = s[i];
        end
        return v;
    endfunction

    // Subject mostly built from pattern bytes, often with a whole copy of
    // the pattern dropped in, so matches and near misses are common.
    task automatic random_subject(input int len);
        int n;
        int i;
        int k;
        int at;
        n = (cfg_length > PAT_MAX) ? PAT_MAX : cfg_length;
        subject_text.delete();
        for (i = 0; i < len; i++) begin
            k = $urandom_range((n > 0) ? n - 1 : PAT_MAX - 1);
            if ($urandom_range(3) == 0) begin
                subject_text.push_back(8'($urandom_range(255)));
            end else begin
                subject_text.push_back(cfg_pattern[k * 8 +: 8]);
            end
        end
        if (n > 0 && len >= n && $urandom_range(2) != 0) begin
            at = $urandom_range(len - n);
            for (i = 0; i < n; i++) begin
                subject_text[at + i] = cfg_pattern[i * 8 +: 8];
            end
        end
        send_subject();
    endtask

    task automatic random_config();
        logic [63:0] pat;
        logic [3:0]  len;
        logic [15:0] start;
        int          j;
        if ($urandom_range(3) == 0) begin
            // two-letter pattern: self-overlapping matches
            for (j = 0; j < PAT_MAX; j++) begin
                pat[j * 8 +: 8] = $urandom_range(1) ? 8'h61 : 8'h62;
            end
        end else begin
            pat = {$urandom, $urandom};
        end
        case ($urandom_range(9))
            0:       len = 4'd0;
            1:       len = 4'($urandom_range(15, 9));
            default: len = 4'($urandom_range(8, 1));
        endcase
        case ($urandom_range(5))
            0:       start = 16'($urandom);
            1:       start = 16'hFFFF;
            2:       start = '0;
            default: start = 16'($urandom_range(30));
        endcase
        reconfigure(pat, len, 1'($urandom_range(1)), start);
    endtask

    // Register defaults: empty pattern in first mode matches at offset 0.
    task automatic test_reset_defaults();
        send_text("AB");
    endtask

    task automatic test_directed_cases();
        int i;
        reconfigure(pack_text("abc"), 4'd3, MODE_FIRST, 16'd1);
        send_text("abcabc");
        reconfigure(pack_text("abc"), 4'd3, MODE_LAST, 16'd0);
        send_text("abcab");
        // match that ends on the subject's final byte
        reconfigure(pack_text("abc"), 4'd3, MODE_FIRST, 16'd0);
        send_text("xabc");
        // pattern longer than the subject
        reconfigure(pack_text("abcdefgh"), 4'd8, MODE_FIRST, 16'd0);
        send_text("abc");
        // length above the maximum is clipped to eight bytes
        reconfigure(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, MODE_LAST, 16'd0);
        subject_text.delete();
        for (i = 0; i < PAT_MAX; i++) begin
            subject_text.push_back(8'hFF);
        end
        send_subject();
        // empty pattern: start offset reached or not, then last mode
        reconfigure(64'd0, 4'd0, MODE_FIRST, 16'd3);
        send_text("abc");
        send_text("ab");
        reconfigure(64'd0, 4'd0, MODE_LAST, 16'hFFFF);
        send_text("x");
    endtask

    // Receiver holds off long enough for the output to fill and the input
    // to stall on the next final byte; the sender keeps offering items.
    task automatic test_backpressure();
        int i;
        reconfigure(pack_text("a"), 4'd1, MODE_FIRST, 16'd0);
        in_gap_max = 0;
        @(posedge i_clk);
        hold_cycles = HOLD_CYCLES;
        @(negedge i_clk);
        for (i = 0; i < 40; i++) begin
            random_subject($urandom_range(2, 1));
        end
        wait_idle();
        in_gap_max = 4;
    endtask

    task automatic test_long_subjects();
        int i;
        in_gap_max  = 0;
        out_gap_max = 0;
        // long subject, last match right at its end
        reconfigure(pack_text("xyz"), 4'd3, MODE_LAST, 16'd0);
        subject_text.delete();
        for (i = 0; i < LONG_LEN - 4; i++) begin
            subject_text.push_back(8'($urandom_range(255)));
        end
        subject_text.push_back(8'h78);
        subject_text.push_back(8'h79);
        subject_text.push_back(8'h7A);
        send_subject();
        // empty pattern with the start offset equal to the length
        reconfigure(64'd0, 4'd0, MODE_FIRST, 16'(LONG_LEN - 1));
        subject_text.delete();
        for (i = 0; i < LONG_LEN - 1; i++) begin
            subject_text.push_back(8'($urandom_range(255)));
        end
        send_subject();
        // same offset, subject a few bytes past it
        subject_text.push_back(8'h00);
        subject_text.push_back(8'hFF);
        subject_text.push_back(8'h5A);
        send_subject();
        wait_idle();
        in_gap_max  = 4;
        out_gap_max = 4;
    endtask

    task automatic test_random_subjects();
        int first_item;
        int subjects;
        int len;
        first_item = items_sent;
        subjects   = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            if (subjects % 6 == 0) begin
                random_config();
                in_gap_max  = ($urandom_range(4) == 0) ? 0 : 4;
                out_gap_max = ($urandom_range(4) == 0) ? 0 : 4;
            end
            if (subjects % 17 == 16) begin
                wait_idle();
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
            random_subject(len);
            subjects++;
        end
    endtask

    // Receiver stall: the long hold first, else the drawn wait per result item.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles--;
        end else if (o_out_valid && out_wait > 0) begin
            i_out_stall <= 1'b1;
            out_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result item with none pending, position",
                                int'(o_out.match_position), -1);
            end else begin
                want = pending_results.pop_front();
                if (o_out.search_status != want.search_status) begin
                    report_mismatch("search_status", int'(o_out.search_status),
                                    int'(want.search_status));
                end
                if (o_out.match_position != want.match_position) begin
                    report_mismatch("match_position", int'(o_out.match_position),
                                    int'(want.match_position));
                end
            end
            out_wait = $urandom_range(out_gap_max);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("substring_search_first_last_test: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_directed_cases();
        test_backpressure();
        test_long_subjects();
        test_random_subjects();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("substring_search_first_last_test: done, clean");
        end else begin
            $display("substring_search_first_last_test: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
sv/sss_pkg.sv
sv/sss_cell.sv
sv/sss_regs.sv
sv/substring_search_first_last.sv
test/substring_search_first_last_test.sv
